/* design/fsr_pkg.sv */
`timescale 1ns / 1ps

package fsr_pkg;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_LOAD   = 2'd1,
    STAT_EVICT  = 2'd2,
    STAT_REJECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_e;

  // per-cell command
  typedef struct packed {
    logic cmp;    // latch hit / fit flags against the incoming beat
    logic shift;  // take the entry of the next younger neighbor
    logic write;  // take the new segment
  } cell_ctl_t;

endpackage

/* design/fsr_cell.sv */
`timescale 1ns / 1ps

module fsr_cell import fsr_pkg::*; #(
  parameter int ID_BITS   = 16,
  parameter int SIZE_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctl_t            ctl_i,
  input  logic                 occ_i,
  input  logic [ID_BITS-1:0]   cmp_id_i,
  input  logic [SIZE_BITS:0]   cmp_need_i,
  input  logic [SIZE_BITS-1:0] total_i,
  input  logic [ID_BITS-1:0]   nb_id_i,
  input  logic [SIZE_BITS-1:0] nb_size_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic [SIZE_BITS-1:0] new_size_i,
  output logic [ID_BITS-1:0]   id_o,
  output logic [SIZE_BITS-1:0] size_o,
  output logic                 hit_o,
  output logic                 fit_o
);

  logic [ID_BITS-1:0]   id_q;
  logic [SIZE_BITS-1:0] size_q;
  logic                 hit_q, hit_d;
  logic                 fit_q, fit_d;
  logic [SIZE_BITS:0]   room;

  // evicting this entry frees total + its size
  assign room  = {1'b0, total_i} + {1'b0, size_q};
  assign hit_d = occ_i && (id_q == cmp_id_i);
  assign fit_d = occ_i && (cmp_need_i <= room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      fit_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      hit_q <= hit_d;
      fit_q <= fit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.write) begin
      id_q   <= new_id_i;
      size_q <= new_size_i;
    end else if (ctl_i.shift) begin
      id_q   <= nb_id_i;
      size_q <= nb_size_i;
    end
  end

  assign id_o   = id_q;
  assign size_o = size_q;
  assign hit_o  = hit_q;
  assign fit_o  = fit_q;

endmodule

/* design/fifo_segment_replacer.sv */
`timescale 1ns / 1ps

// FIFO segment replacer. Each request beat carries a segment id and size; one result beat
// reports hit, load into free space, load with eviction (with the evicted id and size) or
// reject, plus the memory in use afterwards. The table is a row of TABLE_ENTRIES cells, oldest
// entry in cell 0. In the accept cycle every cell compares its entry against the request (id
// match and fit). In the apply state, once the output register is free or being taken, the
// new segment is written on a load or an eviction; on an eviction the first fitting cell is
// the victim and the younger cells shift down one place. The result is loaded into the
// output register. One request is in flight at a time; a result waiting downstream holds off
// the next request only when it has to be overwritten. total_memory is written via cfg_we_i /
// cfg_wdata_i, by the user only while no request is pending; the block does not enforce it.

module fifo_segment_replacer import fsr_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ID_BITS       = 16,
  parameter int SIZE_BITS     = 20,
  localparam int InW  = ((ID_BITS + SIZE_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 + ID_BITS + 2 * SIZE_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SIZE_BITS-1:0] cfg_wdata_i,      // total_memory
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InW-1:0]       s_axis_tdata_i,   // segment_id, segment_size
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutW-1:0]      m_axis_tdata_o    // status, evicted_id, evicted_size, used_after
);

  localparam int N    = TABLE_ENTRIES;
  localparam int CntW = $clog2(N + 1);
  localparam int PadW = OutW - (2 + ID_BITS + 2 * SIZE_BITS);

  state_e               state_q, state_d;
  logic [SIZE_BITS-1:0] total_q;
  logic [SIZE_BITS-1:0] used_q, used_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ID_BITS-1:0]   req_id_q;
  logic [SIZE_BITS-1:0] req_size_q;
  logic                 free_q;
  logic                 out_valid_q;
  logic [OutW-1:0]      out_data_q;

  logic [ID_BITS-1:0]   in_id;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS:0]   in_need;
  logic                 in_fire;
  logic                 apply_go;

  logic [ID_BITS-1:0]   cell_id   [N];
  logic [SIZE_BITS-1:0] cell_size [N];
  cell_ctl_t            cell_ctl  [N];
  logic [N-1:0]         occ_vec, hit_vec, fit_vec, first_vec, ge_vec, write_vec;
  logic [CntW-1:0]      last_idx;
  status_e              status;
  logic [ID_BITS-1:0]   vic_id;
  logic [SIZE_BITS-1:0] vic_size;

  assign in_id    = s_axis_tdata_i[ID_BITS-1:0];
  assign in_size  = s_axis_tdata_i[ID_BITS+SIZE_BITS-1:ID_BITS];
  assign in_need  = {1'b0, in_size} + {1'b0, used_q};
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign apply_go = (state_q == S_APPLY) && (!out_valid_q || m_axis_tready_i);
  assign last_idx = count_q - CntW'(1);

  // first fitting entry as one-hot, and the mask of it and everything younger
  assign first_vec = fit_vec & (~fit_vec + N'(1));
  assign ge_vec    = ~(first_vec - N'(1));

  always_comb begin
    priority if (|hit_vec) begin
      status = STAT_HIT;
    end else if (free_q) begin
      status = STAT_LOAD;
    end else if (|fit_vec) begin
      status = STAT_EVICT;
    end else begin
      status = STAT_REJECT;
    end
  end

  always_comb begin
    vic_id   = '0;
    vic_size = '0;
    for (int i = 0; i < N; i++) begin
      vic_id   = vic_id   | (cell_id[i]   & {ID_BITS{first_vec[i]}});
      vic_size = vic_size | (cell_size[i] & {SIZE_BITS{first_vec[i]}});
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int Nb = (g == N - 1) ? g : g + 1;

    assign occ_vec[g]   = CntW'(g) < count_q;
    assign write_vec[g] = apply_go &&
        (((status == STAT_LOAD) && (CntW'(g) == count_q)) ||
         ((status == STAT_EVICT) && (CntW'(g) == last_idx)));
    assign cell_ctl[g].cmp   = in_fire;
    assign cell_ctl[g].write = write_vec[g];
    assign cell_ctl[g].shift = apply_go && (status == STAT_EVICT) && ge_vec[g] &&
                               (CntW'(g) < last_idx);

    fsr_cell #(
      .ID_BITS   (ID_BITS),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[g]),
      .occ_i      (occ_vec[g]),
      .cmp_id_i   (in_id),
      .cmp_need_i (in_need),
      .total_i    (total_q),
      .nb_id_i    (cell_id[Nb]),
      .nb_size_i  (cell_size[Nb]),
      .new_id_i   (req_id_q),
      .new_size_i (req_size_q),
      .id_o       (cell_id[g]),
      .size_o     (cell_size[g]),
      .hit_o      (hit_vec[g]),
      .fit_o      (fit_vec[g])
    );
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    count_d = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          state_d = S_IDLE;
          unique case (status)
            STAT_LOAD: begin
              used_d  = used_q + req_size_q;
              count_d = count_q + CntW'(1);
            end
            STAT_EVICT: begin
              used_d = used_q + req_size_q - vic_size;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      used_q      <= '0;
      count_q     <= '0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        free_q <= (count_q < CntW'(N)) && (in_need <= {1'b0, total_q});
      end
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_id_q   <= in_id;
      req_size_q <= in_size;
    end
    if (apply_go) begin
      out_data_q <= {{PadW{1'b0}}, used_d,
                     (status == STAT_EVICT) ? vic_size : {SIZE_BITS{1'b0}},
                     (status == STAT_EVICT) ? vic_id   : {ID_BITS{1'b0}},
                     status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q <= CntW'(N))
    else $error("resident count above table size");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $onehot0(write_vec))
    else $error("more than one cell written");

  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_fire |=> (state_q == S_APPLY))
    else $error("accepted beat not applied");

  a_load_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      apply_go && (status == STAT_LOAD || status == STAT_EVICT) |-> used_d <= total_q)
    else $error("load leaves use above capacity");

  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
      apply_go && (status == STAT_EVICT) |-> $onehot(first_vec) && (count_q != '0))
    else $error("eviction without a victim");

endmodule
